/* hdl/spq_pkg.sv */
package spq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int PRIO_BITS_DEFAULT = 8;
    localparam int PAY_BITS          = 8;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FIN,
        S_DEQ,
        S_EMIT
    } state_t;

endpackage

/* hdl/spq_ram.sv */
module spq_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sorted_priority_queue_top.sv */
// Sequence: an enqueue moves each stored entry of lower priority one slot toward the tail,
// stopping at the head or at the compare that meets an entry of equal or higher priority, then
// writes the new entry; a dequeue or a rejected request goes straight to its result state, and
// each result waits there only while the output register is still full.
// Throughput: one request at a time, as in_ready stays low through the shift and the result stage.
// Reset: asynchronous reset empties the queue and sets capacity to DEPTH; the entry RAM is
// left uninitialized and needs no clearing pass.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int PRIO_BITS = PRIO_BITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [$clog2(DEPTH+1)-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [PRIO_BITS-1:0]       entry_priority,
    input  logic [PAY_BITS-1:0]        entry_payload,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [PRIO_BITS-1:0]       out_priority,
    output logic [PAY_BITS-1:0]        out_payload,
    output logic [1:0]                 status,
    output logic [$clog2(DEPTH+1)-1:0] element_count,
    output logic                       is_full,
    output logic                       is_empty
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = PRIO_BITS + PAY_BITS;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                             input logic [CW-1:0] pos,
                                             input logic [CW-1:0] cap);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(pos);
        if (s >= SW'(cap))
        begin
            s = s - SW'(cap);
        end
        return s[IW-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        cap_reg, cap_next;
    logic [CW-1:0]        p_reg, p_next;
    logic [PRIO_BITS-1:0] x_prio_reg, x_prio_next;
    logic [PAY_BITS-1:0]  x_pay_reg, x_pay_next;
    status_t              st_reg, st_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PRIO_BITS-1:0] out_prio_reg, out_prio_next;
    logic [PAY_BITS-1:0]  out_pay_reg, out_pay_next;
    status_t              out_st_reg, out_st_next;
    logic [CW-1:0]        out_count_reg, out_count_next;
    logic                 out_full_reg, out_full_next;
    logic                 out_empty_reg, out_empty_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    logic                 accept;
    logic                 can_emit;
    logic                 shift_go;
    logic                 enq_full;
    logic [CW-1:0]        count_inc;
    logic [CW-1:0]        count_dec;
    logic [CW-1:0]        cfg_clamped;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign can_emit  = !out_valid_reg || out_ready;
    assign shift_go  = (ram_rdata[EW-1:PAY_BITS] < x_prio_reg);
    assign enq_full  = (count_reg >= cap_reg);
    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);

    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped = CW'(1);
        end
        else if (cfg_data > CW'(DEPTH))
        begin
            cfg_clamped = CW'(DEPTH);
        end
    end

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!req_type)
                    begin
                        if (enq_full)
                        begin
                            state_next = S_EMIT;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_CMP;
                        end
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? S_EMIT : S_DEQ;
                    end
                end
            end
            S_CMP:
            begin
                if (!shift_go || p_reg == CW'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN, S_DEQ, S_EMIT:
            begin
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        p_next         = p_reg;
        x_prio_next    = x_prio_reg;
        x_pay_next     = x_pay_reg;
        st_next        = st_reg;
        out_prio_next  = out_prio_reg;
        out_pay_next   = out_pay_reg;
        out_st_next    = out_st_reg;
        out_count_next = out_count_reg;
        out_full_next  = out_full_reg;
        out_empty_next = out_empty_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = slot_of(head_reg, p_reg, cap_reg);
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = slot_of(head_reg, count_dec, cap_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_prio_next = entry_priority;
                    x_pay_next  = entry_payload;
                    st_next     = ST_DONE;
                    if (!req_type)
                    begin
                        if (enq_full)
                        begin
                            st_next = ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            head_next = '0;
                            p_next    = '0;
                        end
                        else
                        begin
                            ram_re = 1'b1;
                            p_next = count_reg;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = head_reg;
                        end
                    end
                end
            end
            S_CMP:
            begin
                if (shift_go)
                begin
                    // The next read is two slots behind the write, so the two never collide.
                    ram_we    = 1'b1;
                    p_next    = p_reg - CW'(1);
                    ram_raddr = slot_of(head_reg, p_reg - CW'(2), cap_reg);
                    ram_re    = (p_reg != CW'(1));
                end
            end
            S_FIN:
            begin
                if (can_emit)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = {x_prio_reg, x_pay_reg};
                    count_next     = count_inc;
                    out_valid_next = 1'b1;
                    out_prio_next  = '0;
                    out_pay_next   = '0;
                    out_st_next    = ST_DONE;
                    out_count_next = count_inc;
                    out_full_next  = (count_inc == cap_reg);
                    out_empty_next = 1'b0;
                end
            end
            S_DEQ:
            begin
                if (can_emit)
                begin
                    count_next     = count_dec;
                    head_next      = (count_dec == '0) ? '0
                                                       : slot_of(head_reg, CW'(1), cap_reg);
                    out_valid_next = 1'b1;
                    out_prio_next  = ram_rdata[EW-1:PAY_BITS];
                    out_pay_next   = ram_rdata[PAY_BITS-1:0];
                    out_st_next    = ST_DONE;
                    out_count_next = count_dec;
                    out_full_next  = (count_dec == cap_reg);
                    out_empty_next = (count_dec == '0);
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_prio_next  = '0;
                    out_pay_next   = '0;
                    out_st_next    = st_reg;
                    out_count_next = count_reg;
                    out_full_next  = (count_reg == cap_reg);
                    out_empty_next = (count_reg == '0);
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_valid)
        begin
            cap_next   = cfg_clamped;
            head_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CW'(DEPTH);
            p_reg         <= '0;
            st_reg        <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            p_reg         <= p_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_prio_reg    <= x_prio_next;
        x_pay_reg     <= x_pay_next;
        out_prio_reg  <= out_prio_next;
        out_pay_reg   <= out_pay_next;
        out_st_reg    <= out_st_next;
        out_count_reg <= out_count_next;
        out_full_reg  <= out_full_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_priority  = out_prio_reg;
    assign out_payload   = out_pay_reg;
    assign status        = out_st_reg;
    assign element_count = out_count_reg;
    assign is_full       = out_full_reg;
    assign is_empty      = out_empty_reg;

endmodule

/* hdl/spq_checker.sv */
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int PRIO_BITS = PRIO_BITS_DEFAULT
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [$clog2(DEPTH+1)-1:0] cfg_data,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       req_type,
    input logic [PRIO_BITS-1:0]       entry_priority,
    input logic [PAY_BITS-1:0]        entry_payload,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [PRIO_BITS-1:0]       out_priority,
    input logic [PAY_BITS-1:0]        out_payload,
    input logic [1:0]                 status,
    input logic [$clog2(DEPTH+1)-1:0] element_count,
    input logic                       is_full,
    input logic                       is_empty
);

    out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_priority)
            && $stable(out_payload) && $stable(status) && $stable(element_count))
        else $error("result item changed while stalled");

    one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request item accepted while another is in flight");

    empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (element_count == '0)))
        else $error("empty flag disagrees with element count");

    no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> out_priority == '0 && out_payload == '0)
        else $error("rejected request item carries an entry");

    full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> is_full && !is_empty)
        else $error("full rejection without a full queue");

endmodule

bind sorted_priority_queue_top spq_checker #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
) u_spq_checker (.*);

/* bench/tb.sv */
module tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam bit REQ_ENQ = 1'b0;
    localparam bit REQ_DEQ = 1'b1;

    typedef struct {
        logic [PRIO_BITS_DEFAULT-1:0] prio;
        logic [PAY_BITS-1:0]          pay;
    } entry_t;

    typedef struct {
        logic [PRIO_BITS_DEFAULT-1:0] prio;
        logic [PAY_BITS-1:0]          pay;
        status_t                      code;
        logic [CW-1:0]                count;
        logic                         full;
        logic                         empty;
    } response_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CW-1:0]                cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         req_type = REQ_ENQ;
    logic [PRIO_BITS_DEFAULT-1:0] entry_priority = '0;
    logic [PAY_BITS-1:0]          entry_payload = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [PRIO_BITS_DEFAULT-1:0] out_priority;
    logic [PAY_BITS-1:0]          out_payload;
    logic [1:0]                   status;
    logic [CW-1:0]                element_count;
    logic                         is_full;
    logic                         is_empty;

    entry_t    held_entries[$];
    response_t awaited_responses[$];
    int        slots_in_use = DEPTH;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        mismatches = 0;
    int        responses_seen = 0;
    int        enqueues_done = 0;
    int        dequeues_done = 0;
    int        full_rejects = 0;
    int        empty_rejects = 0;
    int        capacity_writes = 0;

    sorted_priority_queue_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .entry_priority (entry_priority),
        .entry_payload  (entry_payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_priority   (out_priority),
        .out_payload    (out_payload),
        .status         (status),
        .element_count  (element_count),
        .is_full        (is_full),
        .is_empty       (is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic response_t serve_request(bit deq, logic [7:0] prio, logic [7:0] pay);
        response_t r;
        entry_t    e;
        int        pos;
        r.prio = '0;
        r.pay  = '0;
        r.code = ST_DONE;
        if (deq == REQ_ENQ) begin
            if (held_entries.size() >= slots_in_use) begin
                r.code = ST_FULL;
                full_rejects++;
            end
            else begin
                e.prio = prio;
                e.pay  = pay;
                pos = held_entries.size();
                while (pos > 0 && held_entries[pos-1].prio < prio)
                    pos--;
                held_entries.insert(pos, e);
                enqueues_done++;
            end
        end
        else begin
            if (held_entries.size() == 0) begin
                r.code = ST_EMPTY;
                empty_rejects++;
            end
            else begin
                e = held_entries.pop_front();
                r.prio = e.prio;
                r.pay  = e.pay;
                dequeues_done++;
            end
        end
        r.count = CW'(held_entries.size());
        r.full  = (held_entries.size() == slots_in_use);
        r.empty = (held_entries.size() == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] response %0d: %s is %0d, expected %0d",
                 $realtime, responses_seen, field, got, want);
        mismatches++;
    endtask

    always @(negedge clk)
    begin
        response_t want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_responses.size() == 0) begin
                report_mismatch("unexpected response, status", int'(status), 0);
            end
            else begin
                want = awaited_responses.pop_front();
                if (out_priority !== want.prio)
                    report_mismatch("out_priority", int'(out_priority), int'(want.prio));
                if (out_payload !== want.pay)
                    report_mismatch("out_payload", int'(out_payload), int'(want.pay));
                if (status !== want.code)
                    report_mismatch("status", int'(status), int'(want.code));
                if (element_count !== want.count)
                    report_mismatch("element_count", int'(element_count), int'(want.count));
                if (is_full !== want.full)
                    report_mismatch("is_full", int'(is_full), int'(want.full));
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", int'(is_empty), int'(want.empty));
            end
            responses_seen++;
        end
    end

    task automatic send_request(bit deq, logic [7:0] prio, logic [7:0] pay);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= deq;
        entry_priority <= prio;
        entry_payload  <= pay;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        awaited_responses.push_back(serve_request(deq, prio, pay));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CW-1:0] value);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (value == 0)
            slots_in_use = 1;
        else if (value > DEPTH)
            slots_in_use = DEPTH;
        else
            slots_in_use = int'(value);
        held_entries.delete();
        capacity_writes++;
    endtask

    task automatic test_rejects();
        send_request(REQ_DEQ, 8'h00, 8'h00);
        write_capacity('0);
        send_request(REQ_ENQ, 8'hFF, 8'hFF);
        send_request(REQ_ENQ, 8'h00, 8'h00);
        send_request(REQ_DEQ, 8'h00, 8'h00);
        send_request(REQ_DEQ, 8'hFF, 8'hFF);
    endtask

    task automatic test_priority_order();
        write_capacity(CW'(4));
        send_request(REQ_ENQ, 8'h00, 8'h00);
        send_request(REQ_ENQ, 8'h80, 8'h55);
        send_request(REQ_ENQ, 8'h80, 8'hAA);
        send_request(REQ_ENQ, 8'hFF, 8'hFF);
        send_request(REQ_ENQ, 8'h7F, 8'h11);
        repeat (4) send_request(REQ_DEQ, 8'h00, 8'h00);
    endtask

    task automatic test_capacity_write_clears();
        write_capacity(CW'(DEPTH));
        send_request(REQ_ENQ, 8'h01, 8'h01);
        send_request(REQ_ENQ, 8'hFE, 8'hFE);
        write_capacity({CW{1'b1}});
        send_request(REQ_DEQ, 8'h00, 8'h00);
    endtask

    task automatic test_random_traffic(int count);
        int         enq_bias;
        logic [7:0] prio;
        enq_bias = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                case ($urandom_range(2))
                    0: enq_bias = 15;
                    1: enq_bias = 50;
                    default: enq_bias = 85;
                endcase
            end
            case ($urandom_range(3))
                0: prio = 8'($urandom_range(3));
                1: prio = $urandom_range(1) ? 8'hFF : 8'h00;
                default: prio = 8'($urandom_range(255));
            endcase
            send_request($urandom_range(99) >= enq_bias, prio, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int capacities[5];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 25;
        recv_stall_pct = 47;
        test_rejects();
        test_priority_order();
        test_capacity_write_clears();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct  = (mode == 0) ? 25 : (mode == 1) ? 47 : 0;
            recv_stall_pct = (mode == 0) ? 47 : (mode == 1) ? 25 : 0;
            capacities = '{DEPTH, 1, $urandom_range(2, DEPTH - 1),
                           $urandom_range(DEPTH + 1, 31), $urandom_range(0, 31)};
            foreach (capacities[k]) begin
                write_capacity(CW'(capacities[k]));
                test_random_traffic(100);
            end
        end

        wait_drained();
        repeat (DEPTH + 4) @(posedge clk);
        $display("Checked %0d responses: %0d enqueues, %0d dequeues, %0d full and %0d empty",
                 responses_seen, enqueues_done, dequeues_done, full_rejects, empty_rejects);
        $display("rejects, across %0d capacity writes and three backpressure mixes.",
                 capacity_writes);
        if (mismatches == 0 && awaited_responses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d responses outstanding.", awaited_responses.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
